[rtl/core/vbpf_pkg.sv]
// Shared types and constants of the voxel background point filter.
package vbpf_pkg;

  // Count store geometry
  localparam int unsigned STORE_BITS = 17;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Register reset values
  localparam logic [COORD_W-1:0] ORIGIN_X_RST  = 16'hC400;  // -15360
  localparam logic [COORD_W-1:0] ORIGIN_Y_RST  = 16'hC400;  // -15360
  localparam logic [COORD_W-1:0] ORIGIN_Z_RST  = 16'hFE00;  // -512
  localparam logic [SHIFT_W-1:0] CELL_SHIFT_RST = 4'd8;
  localparam logic [COUNT_W-1:0] THRESHOLD_RST = 16'd400;

  // Item kinds
  localparam logic KIND_LEARN  = 1'b0;
  localparam logic KIND_FILTER = 1'b1;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X        = 3'd0,
    REG_ORIGIN_Y        = 3'd1,
    REG_ORIGIN_Z        = 3'd2,
    REG_CELL_SHIFT      = 3'd3,
    REG_COUNT_THRESHOLD = 3'd4
  } cfg_reg_t;

  // Control carried beside each word through the pipeline
  typedef struct packed {
    logic valid;
    logic kind;
    logic in_grid;
  } stage_ctl_t;

  // One result word
  typedef struct packed {
    logic                  keep;
    logic                  in_grid;
    logic [STORE_BITS-1:0] cell_index;
    logic [COUNT_W-1:0]    cell_count;
  } result_t;

endpackage

[rtl/core/voxel_background_point_filter.sv]
// Voxel background point filter: grid mapping, voxel count store, keep decision.
//
// Input words arrive on s_axis_*: tuser carries the kind (learn or filter),
// tdata the point x, y, z. Each word yields exactly one result word on
// m_axis_*: keep and in_grid in tuser, the voxel index and count in tdata.
// Configuration registers are written over cfg_valid/cfg_index/cfg_data,
// which is always ready; write them only while no word is in flight.
//
// Throughput is one word per cycle while the store is not being cleared and
// the skid register is empty. A word passes grid mapping at the accepting
// edge, two constant multiplies for the index, the count store read, then
// the count update and the output register. The count store is a 131072 x 16
// RAM; a learn word writes its voxel back from stage D, after the read, and a
// one-entry bypass covers a word that reads the voxel just written.
//
// After reset the block clears all 131072 entries of the count store, one
// entry per cycle; s_axis_tready stays low meanwhile. A stall on m_axis_tready
// fills a one-word skid register, after which s_axis_tready drops and the
// whole pipeline holds until the receiver takes the output word.
module voxel_background_point_filter #(
  parameter int unsigned X_CELLS = 128,
  parameter int unsigned Y_CELLS = 128,
  parameter int unsigned Z_CELLS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], pos_z[47:32]
  input  logic        s_axis_tuser,   // kind
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // cell_index[16:0], cell_count[32:17], zero
  output logic [1:0]  m_axis_tuser,   // keep[0], in_grid[1]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [vbpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned SB = vbpf_pkg::STORE_BITS;
  localparam int unsigned CW = vbpf_pkg::COUNT_W;
  localparam int unsigned XW = (X_CELLS > 1) ? $clog2(X_CELLS) : 1;
  localparam int unsigned YW = (Y_CELLS > 1) ? $clog2(Y_CELLS) : 1;
  localparam int unsigned ZW = (Z_CELLS > 1) ? $clog2(Z_CELLS) : 1;

  // Cell number along one axis: {inside, cell}
  function automatic logic [16:0] axis_cell(
    input logic [15:0] pos,
    input logic [15:0] org,
    input logic [3:0]  sh,
    input logic [10:0] cells
  );
    logic [16:0] diff;
    logic [15:0] c;
    diff = {pos[15], pos} - {org[15], org};
    c    = diff[15:0] >> sh;
    return {(!diff[16]) && ({1'b0, c} < {6'd0, cells}), c};
  endfunction

  // Configuration registers
  logic [15:0]   origin_x, origin_y, origin_z;
  logic [3:0]    cell_shift;
  logic [CW-1:0] count_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x        <= vbpf_pkg::ORIGIN_X_RST;
      origin_y        <= vbpf_pkg::ORIGIN_Y_RST;
      origin_z        <= vbpf_pkg::ORIGIN_Z_RST;
      cell_shift      <= vbpf_pkg::CELL_SHIFT_RST;
      count_threshold <= vbpf_pkg::THRESHOLD_RST;
    end else if (cfg_valid) begin
      unique case (vbpf_pkg::cfg_reg_t'(cfg_index))
        vbpf_pkg::REG_ORIGIN_X:        origin_x        <= cfg_data;
        vbpf_pkg::REG_ORIGIN_Y:        origin_y        <= cfg_data;
        vbpf_pkg::REG_ORIGIN_Z:        origin_z        <= cfg_data;
        vbpf_pkg::REG_CELL_SHIFT:      cell_shift      <= cfg_data[3:0];
        vbpf_pkg::REG_COUNT_THRESHOLD: count_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing pass over the count store after reset
  logic          clearing;
  logic [SB-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  // Pipeline enable: hold everything while the skid register is full
  logic skid_valid;
  logic en;
  logic s_accept;

  assign en            = !skid_valid;
  assign s_axis_tready = en && !clearing;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Stage A: grid mapping
  logic [16:0] ax_x, ax_y, ax_z;
  assign ax_x = axis_cell(s_axis_tdata[15:0],  origin_x, cell_shift, 11'(X_CELLS));
  assign ax_y = axis_cell(s_axis_tdata[31:16], origin_y, cell_shift, 11'(Y_CELLS));
  assign ax_z = axis_cell(s_axis_tdata[47:32], origin_z, cell_shift, 11'(Z_CELLS));

  vbpf_pkg::stage_ctl_t a_ctl, b_ctl, c_ctl, d_ctl;
  logic [XW-1:0] a_cx, b_cx;
  logic [YW-1:0] a_cy;
  logic [ZW-1:0] a_cz;
  logic [SB-1:0] b_zy, c_idx, d_idx;

  // Advance the control of each stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
      b_ctl <= '0;
      c_ctl <= '0;
      d_ctl <= '0;
    end else if (en) begin
      a_ctl <= '{valid: s_accept, kind: s_axis_tuser,
                 in_grid: ax_x[16] && ax_y[16] && ax_z[16]};
      b_ctl <= a_ctl;
      c_ctl <= b_ctl;
      d_ctl <= c_ctl;
    end
  end

  // Stages A to D: cell numbers, then index = (cz * Y + cy) * X + cx
  always_ff @(posedge clk) begin
    if (en) begin
      a_cx  <= ax_x[XW-1:0];
      a_cy  <= ax_y[YW-1:0];
      a_cz  <= ax_z[ZW-1:0];
      b_cx  <= a_cx;
      b_zy  <= SB'(SB'(a_cz) * SB'(Y_CELLS) + SB'(a_cy));
      c_idx <= SB'(b_zy * SB'(X_CELLS) + SB'(b_cx));
      d_idx <= c_idx;
    end
  end

  // Count store
  logic          wr_en;
  logic [SB-1:0] wr_addr;
  logic [CW-1:0] wr_data;
  logic [CW-1:0] rd_data;

  vbpf_ram #(
    .DATA_W (CW),
    .DEPTH  (1 << SB)
  ) u_counts (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (en),
    .rd_addr (c_idx),
    .rd_data (rd_data)
  );

  // Stage D: bypass the write made at the edge of this word's read
  logic          w_valid;
  logic [SB-1:0] w_idx;
  logic [CW-1:0] w_data;
  logic [CW-1:0] cur_count, new_count;
  logic          learn_wr;
  vbpf_pkg::result_t d_res;

  always_comb begin
    cur_count = (w_valid && (w_idx == d_idx)) ? w_data : rd_data;
    new_count = (cur_count == vbpf_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;
    learn_wr  = en && d_ctl.valid && d_ctl.in_grid && (d_ctl.kind == vbpf_pkg::KIND_LEARN);
    d_res     = '0;
    if (d_ctl.in_grid) begin
      d_res.in_grid    = 1'b1;
      d_res.cell_index = d_idx;
      if (d_ctl.kind == vbpf_pkg::KIND_LEARN) begin
        d_res.cell_count = new_count;
      end else begin
        d_res.cell_count = cur_count;
        d_res.keep       = (cur_count <= count_threshold);
      end
    end
  end

  // Store write: clearing pass or learn update
  always_comb begin
    wr_en   = clearing || learn_wr;
    wr_addr = clearing ? clr_addr : d_idx;
    wr_data = clearing ? '0 : new_count;
  end

  // Remember the write for the next word's bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (en) begin
      w_valid <= learn_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (learn_wr) begin
      w_idx  <= d_idx;
      w_data <= new_count;
    end
  end

  // Output register and skid register
  logic              o_valid;
  vbpf_pkg::result_t o_res, skid_res;
  logic              in_v;

  assign in_v = en && d_ctl.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!o_valid || m_axis_tready) begin
      if (skid_valid) begin
        o_valid    <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        o_valid <= in_v;
      end
    end else if (in_v) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || m_axis_tready) begin
      o_res <= skid_valid ? skid_res : d_res;
    end else if (in_v) begin
      skid_res <= d_res;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {7'd0, o_res.cell_count, o_res.cell_index};
  assign m_axis_tuser  = {o_res.in_grid, o_res.keep};

`ifndef ASSERT_OFF
  // No word enters while the store is being cleared
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("word accepted during clearing pass");

  // The skid register only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> o_valid)
    else $error("skid register full with output empty");

  // A point outside the grid gives an all-zero result
  a_out_of_grid_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_res.in_grid) |-> (!o_res.keep && o_res.cell_count == '0 &&
                                     o_res.cell_index == '0))
    else $error("out-of-grid result not zero");

  // No store write from the pipeline while it is stalled
  a_no_write_stalled: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !learn_wr)
    else $error("count written while pipeline held");
`endif

endmodule

[rtl/core/vbpf_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module vbpf_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
